// ----- hdl/fdrf_pkg.sv -----
// Shared sizes, field widths and payload types for the frame dirty region finder.
`default_nettype none

package fdrf_pkg;

    // Frame geometry in byte columns and rows
    localparam int ROW_BYTES   = 16;
    localparam int ROWS        = 296;
    localparam int BYTE_PIXELS = 8;
    localparam int PIX_SHIFT   = $clog2(BYTE_PIXELS);

    // Counter widths follow the geometry
    localparam int COL_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(ROW_BYTES - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    // Result field widths
    localparam int X_W      = 7;
    localparam int Y_W      = 9;
    localparam int WIDTH_W  = 8;
    localparam int HEIGHT_W = 9;

    // Stream data widths
    localparam int IN_TDATA_W  = 32;
    localparam int RES_W       = 1 + X_W + Y_W + WIDTH_W + HEIGHT_W;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RES_W;

    // One byte position, last field in the lowest bits
    typedef struct packed {
        logic [7:0] new_red_byte;
        logic [7:0] new_black_byte;
        logic [7:0] old_red_byte;
        logic [7:0] old_black_byte;
    } t_item;

    // One region result, last field in the lowest bits
    typedef struct packed {
        logic [HEIGHT_W-1:0] region_height;
        logic [WIDTH_W-1:0]  region_width;
        logic [Y_W-1:0]      region_y;
        logic [X_W-1:0]      region_x;
        logic                changed;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/frame_dirty_region_finder.sv -----
// Frame dirty region finder: tracks changed byte positions and reports their bounding box.
//
// Usage:
//   Slave stream (i_s_*): one byte position of a two-plane e-paper frame per request, in
//   raster order, old and new black and red bytes side by side. Column and row are counted
//   inside, so the first request after reset or after a frame end is column 0, row 0.
//   Master stream (o_m_*): one result per frame, issued for the last byte position of the
//   frame: a changed flag and the bounding region (x and width in pixels, whole bytes).
//   Latency: the result is valid in the cycle after the last byte is accepted.
//   Throughput: one byte position per cycle; the compare and min/max update sit between the
//   input port and the tracker registers, the result formatting before the output register.
//   Stall: while a result waits on i_m_tready, byte positions keep flowing; only the last
//   byte of the next frame is held off until the waiting result is taken.
//   Reset: synchronous, active low; clears the counters, the trackers and the output valid.
//   No result is lost or repeated across stalls.
`default_nettype none

module frame_dirty_region_finder
    import fdrf_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Byte position stream
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    // [7:0] old_black_byte, [15:8] old_red_byte, [23:16] new_black_byte,
    // [31:24] new_red_byte
    input  wire [IN_TDATA_W-1:0]   i_s_tdata,
    // Region result stream
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    // [0] changed, [7:1] region_x, [16:8] region_y, [24:17] region_width,
    // [33:25] region_height, [39:34] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    t_item            w_item;
    logic             w_diff;
    logic             w_col_last;
    logic             w_row_last;
    logic             w_frame_end;
    logic             w_in_acc;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_seen, n_seen;
    logic [COL_W-1:0] r_least_col, n_least_col;
    logic [COL_W-1:0] r_great_col, n_great_col;
    logic [ROW_W-1:0] r_least_row, n_least_row;
    logic [ROW_W-1:0] r_great_row, n_great_row;

    logic             w_upd_seen;
    logic [COL_W-1:0] w_upd_least_col;
    logic [COL_W-1:0] w_upd_great_col;
    logic [ROW_W-1:0] w_upd_least_row;
    logic [ROW_W-1:0] w_upd_great_row;

    logic [COL_W:0]   w_col_span;
    logic [ROW_W:0]   w_row_span;
    t_result          w_res;

    logic             r_out_valid, n_out_valid;
    t_result          r_res;

    assign w_item = t_item'(i_s_tdata);

    // Detect a changed position and the frame end
    assign w_diff      = (w_item.old_black_byte != w_item.new_black_byte) ||
                         (w_item.old_red_byte != w_item.new_red_byte);
    assign w_col_last  = (r_col >= COL_LAST);
    assign w_row_last  = (r_row >= ROW_LAST);
    assign w_frame_end = w_col_last && w_row_last;

    // Hold off only the frame-end request while a result still waits
    assign o_s_tready = !r_out_valid || i_m_tready || !w_frame_end;
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    // Fold this position into the trackers
    always_comb begin
        w_upd_seen      = r_seen;
        w_upd_least_col = r_least_col;
        w_upd_great_col = r_great_col;
        w_upd_least_row = r_least_row;
        w_upd_great_row = r_great_row;
        if (w_diff) begin
            w_upd_seen = 1'b1;
            if (!r_seen || (r_col < r_least_col)) begin
                w_upd_least_col = r_col;
            end
            if (!r_seen || (r_col > r_great_col)) begin
                w_upd_great_col = r_col;
            end
            if (!r_seen || (r_row < r_least_row)) begin
                w_upd_least_row = r_row;
            end
            if (!r_seen || (r_row > r_great_row)) begin
                w_upd_great_row = r_row;
            end
        end
    end

    // Format the region from the updated trackers
    always_comb begin
        w_col_span = (COL_W + 1)'(w_upd_great_col) - (COL_W + 1)'(w_upd_least_col)
                     + (COL_W + 1)'(1);
        w_row_span = (ROW_W + 1)'(w_upd_great_row) - (ROW_W + 1)'(w_upd_least_row)
                     + (ROW_W + 1)'(1);
        if (w_upd_seen) begin
            w_res.changed       = 1'b1;
            w_res.region_x      = X_W'({w_upd_least_col, PIX_SHIFT'(0)});
            w_res.region_y      = Y_W'(w_upd_least_row);
            w_res.region_width  = WIDTH_W'({w_col_span, PIX_SHIFT'(0)});
            w_res.region_height = HEIGHT_W'(w_row_span);
        end else begin
            w_res = '0;
        end
    end

    // Advance counters, clear trackers at the frame end
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_seen      = r_seen;
        n_least_col = r_least_col;
        n_great_col = r_great_col;
        n_least_row = r_least_row;
        n_great_row = r_great_row;
        if (w_in_acc) begin
            if (w_col_last) begin
                n_col = '0;
                n_row = w_row_last ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
            if (w_frame_end) begin
                n_seen      = 1'b0;
                n_least_col = COL_LAST;
                n_great_col = '0;
                n_least_row = ROW_LAST;
                n_great_row = '0;
            end else begin
                n_seen      = w_upd_seen;
                n_least_col = w_upd_least_col;
                n_great_col = w_upd_great_col;
                n_least_row = w_upd_least_row;
                n_great_row = w_upd_great_row;
            end
        end
    end

    // Load the result slot at a frame end, drop it when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_in_acc && w_frame_end) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control and tracker registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_seen      <= 1'b0;
            r_least_col <= COL_LAST;
            r_great_col <= '0;
            r_least_row <= ROW_LAST;
            r_great_row <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_seen      <= n_seen;
            r_least_col <= n_least_col;
            r_great_col <= n_great_col;
            r_least_row <= n_least_row;
            r_great_row <= n_great_row;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_frame_end) begin
            r_res <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {OUT_PAD_W'(0), r_res};

    // A result only appears after a frame-end request
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_in_acc && w_frame_end))
        else $error("result appeared without a frame-end request");

    // Trackers sit at their cleared values until a change is seen
    a_clear_trackers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> (r_least_col == COL_LAST) && (r_great_col == '0) &&
                    (r_least_row == ROW_LAST) && (r_great_row == '0))
        else $error("trackers not cleared while no change seen");

    // Bounds stay ordered once a change is seen
    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_least_col <= r_great_col) && (r_least_row <= r_great_row))
        else $error("tracked bounds out of order");

    // An unchanged frame reports an all-zero region
    a_zero_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.changed) |-> (r_res == '0))
        else $error("unchanged frame with nonzero region");

    // Row and column counters never pass the last row and column
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= ROW_LAST) && (r_col <= COL_LAST))
        else $error("position counter out of range");

endmodule

`default_nettype wire
